// File: rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, codes, control structs and the ranking compare of the
// streaming top-k frequency ranker.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int VALUE_BITS = 8;
  localparam int TOP_MAX    = 16;
  localparam int COUNT_BITS = 16;

  localparam int CNT_DEPTH  = 1 << VALUE_BITS;
  localparam int IDX_W      = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
  localparam int SIZE_W     = $clog2(TOP_MAX + 1);
  localparam int TOPK_W     = 5;
  localparam int N_W        = (SIZE_W > TOPK_W) ? SIZE_W : TOPK_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [TOPK_W-1:0]     TOPK_RESET = TOPK_W'(1);

  // command bundle, controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic lookup;    // apply restart, read the count memory
    logic update;    // bump the count, match against the list
    logic locate;    // pick the slot and rank compares
    logic insert;    // shift the list, size the result burst
    logic advance;   // one result taken
  } ctrl_cmd_t;

  // status bundle, datapath to controller
  typedef struct packed {
    logic emit_none; // no result for this item (valid in insert)
    logic last_rank; // current result is the final one
  } dp_sts_t;

  // higher count first, smaller value first on a tie
  function automatic logic ranks_before(
    input logic [COUNT_BITS-1:0] ca,
    input logic [VALUE_BITS-1:0] va,
    input logic [COUNT_BITS-1:0] cb,
    input logic [VALUE_BITS-1:0] vb
  );
    logic res;
    if (ca != cb) begin
      res = (ca > cb);
    end else begin
      res = (va < vb);
    end
    return res;
  endfunction

endpackage

// File: rtl/stream_top_k_frequent_top.sv
// ----------------------------------------------------------------------------
// stream_top_k_frequent_top
// Streaming top-k frequency ranker: counts each item's value and emits the
// current most frequent values in rank order after every item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item carries in_item_value and
//   in_restart. in_restart clears every count and the ranked list before the
//   value is counted. in_stall is high from acceptance until the last result
//   of that item has been taken, so one item is in flight at a time.
//   Result channel (out_valid / out_stall): after each item the block sends
//   min(top_k, distinct values seen, 16) results, highest count first and the
//   smaller value first on equal counts; out_last marks the final one. An
//   item that yields no result (top_k of zero) sends nothing.
//   After the accepting edge the block steps through lookup, count
//   update, slot search and insertion, then sends the results one after
//   another. A stalled result holds its value and the block waits.
//   Reset clears all counts through per-value valid bits at once, empties
//   the list and sets top_k to 1; no clearing pass is needed.
//   Configuration: APB port, top_k at address 0. The user must write top_k
//   only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stream_top_k_frequent_top
  import skf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_item_value,
  input  logic                  in_restart,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_top_value,
  output logic                  out_last,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  ctrl_cmd_t         cmd;
  dp_sts_t           sts;
  logic [TOPK_W-1:0] top_k_r;
  logic              sel_top_k;

  // top_k occupies the first word; higher words read as zero and drop writes
  assign sel_top_k = !paddr[2];
  assign pready    = 1'b1;
  assign prdata    = sel_top_k ? 32'(top_k_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_k_r <= TOPK_RESET;
    end else if (psel && penable && pwrite && sel_top_k) begin
      top_k_r <= pwdata[TOPK_W-1:0];
    end
  end

  // sequencer: handshakes and step commands
  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // counts, ranked list and result selection
  skf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .item_value (in_item_value),
    .restart    (in_restart),
    .top_k      (top_k_r),
    .top_value  (out_top_value)
  );

  // last flag follows the result counter; only looked at while out_valid
  assign out_last = sts.last_rank;

endmodule

// File: rtl/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer: accepts one item, steps the datapath through lookup, update,
// locate and insert, then hands out the ranked results one per handshake.
// ----------------------------------------------------------------------------
module skf_ctrl
  import skf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t cmd,
  input  dp_sts_t   sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOKUP = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_LOCATE = 3'd3;
  localparam logic [2:0] S_INSERT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    cmd         = '0;
    cmd.capture = in_valid && (state_r == S_IDLE);
    cmd.lookup  = (state_r == S_LOOKUP);
    cmd.update  = (state_r == S_UPDATE);
    cmd.locate  = (state_r == S_LOCATE);
    cmd.insert  = (state_r == S_INSERT);
    cmd.advance = (state_r == S_EMIT) && !out_stall;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_LOCATE;
      S_LOCATE: state_nxt = S_INSERT;
      S_INSERT: begin
        state_nxt = sts.emit_none ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall && sts.last_rank) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_LOOKUP)
    else $error("accepted item did not start a lookup");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance && sts.last_rank |=> state_r == S_IDLE)
    else $error("burst did not end on its last result");

  a_empty_burst: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && sts.emit_none |=> state_r == S_IDLE)
    else $error("empty burst entered emit");

endmodule

// File: rtl/skf_dpath.sv
// ----------------------------------------------------------------------------
// skf_dpath
// Datapath: count memory with per-entry valid bits, the ranked list in
// registers, one-step insertion by parallel compare and shift, and the
// result counter.
// ----------------------------------------------------------------------------
module skf_dpath
  import skf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  logic [VALUE_BITS-1:0] item_value,
  input  logic                  restart,
  input  logic [TOPK_W-1:0]     top_k,
  output logic [VALUE_BITS-1:0] top_value
);

  // count memory, registered read
  logic [COUNT_BITS-1:0] mem [CNT_DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [CNT_DEPTH-1:0]  valid_r;

  // accepted item
  logic [VALUE_BITS-1:0] v_r;
  logic                  restart_r;

  // ranked list
  logic [VALUE_BITS-1:0] rv_r [TOP_MAX];
  logic [COUNT_BITS-1:0] rc_r [TOP_MAX];
  logic [VALUE_BITS-1:0] rv_nxt [TOP_MAX];
  logic [COUNT_BITS-1:0] rc_nxt [TOP_MAX];
  logic [SIZE_W-1:0]     size_r, size_nxt;

  // per-item work registers
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  inc_ok_r;
  logic [TOP_MAX-1:0]    match_r;
  logic [TOP_MAX-1:0]    bef_r, bef_nxt;
  logic [IDX_W-1:0]      p_r, p_nxt;
  logic                  place_r, place_nxt;
  logic                  append_r, append_nxt;
  logic [IDX_W-1:0]      q;

  // result burst
  logic [SIZE_W-1:0]     n_r, n_nxt, lim;
  logic [IDX_W-1:0]      k_r;

  logic [COUNT_BITS-1:0] cur;
  logic [TOP_MAX-1:0]    match_nxt;

  assign cur = valid_r[v_r] ? rd_data_r : '0;

  always_comb begin
    for (int k = 0; k < TOP_MAX; k++) begin
      match_nxt[k] = (SIZE_W'(k) < size_r) && (rv_r[k] == v_r);
    end
  end

  // slot for the counted value and its rank compares
  always_comb begin
    logic [IDX_W-1:0] enc;
    enc = '0;
    for (int k = 0; k < TOP_MAX; k++) begin
      if (match_r[k]) enc = IDX_W'(k);
      bef_nxt[k] = ranks_before(cnt_r, v_r, rc_r[k], rv_r[k]);
    end
    p_nxt      = '0;
    place_nxt  = 1'b0;
    append_nxt = 1'b0;
    if (inc_ok_r) begin
      if (|match_r) begin
        p_nxt     = enc;
        place_nxt = 1'b1;
      end else if (size_r != SIZE_W'(TOP_MAX)) begin
        p_nxt      = size_r[IDX_W-1:0];
        place_nxt  = 1'b1;
        append_nxt = 1'b1;
      end else if (ranks_before(cnt_r, v_r, rc_r[TOP_MAX-1], rv_r[TOP_MAX-1])) begin
        p_nxt     = IDX_W'(TOP_MAX - 1);
        place_nxt = 1'b1;
      end
    end
  end

  // move up: land at the first entry it outranks, shift the rest down
  always_comb begin
    q = p_r;
    for (int k = TOP_MAX - 1; k >= 0; k--) begin
      if (bef_r[k] && (IDX_W'(k) < p_r)) q = IDX_W'(k);
    end
    for (int k = 0; k < TOP_MAX; k++) begin
      rv_nxt[k] = rv_r[k];
      rc_nxt[k] = rc_r[k];
    end
    if (place_r) begin
      for (int k = 1; k < TOP_MAX; k++) begin
        if ((IDX_W'(k) > q) && (IDX_W'(k) <= p_r)) begin
          rv_nxt[k] = rv_r[k-1];
          rc_nxt[k] = rc_r[k-1];
        end
      end
      for (int k = 0; k < TOP_MAX; k++) begin
        if (IDX_W'(k) == q) begin
          rv_nxt[k] = v_r;
          rc_nxt[k] = cnt_r;
        end
      end
    end
  end

  assign size_nxt = append_r ? size_r + SIZE_W'(1) : size_r;
  assign lim      = (N_W'(top_k) > N_W'(TOP_MAX)) ? SIZE_W'(TOP_MAX) : SIZE_W'(top_k);
  assign n_nxt    = (lim < size_nxt) ? lim : size_nxt;

  assign sts.emit_none = (n_nxt == '0);
  assign sts.last_rank = ((SIZE_W'(k_r) + SIZE_W'(1)) == n_r);
  assign top_value     = rv_r[k_r];

  // count memory
  always_ff @(posedge clk) begin
    if (cmd.update && (cur != CNT_MAX)) begin
      mem[v_r] <= cur + COUNT_BITS'(1);
    end
    if (cmd.lookup) begin
      rd_data_r <= mem[v_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_r       <= item_value;
      restart_r <= restart;
    end
    if (cmd.update) begin
      cnt_r    <= cur + COUNT_BITS'(1);
      inc_ok_r <= (cur != CNT_MAX);
      match_r  <= match_nxt;
    end
    if (cmd.locate) begin
      p_r      <= p_nxt;
      place_r  <= place_nxt;
      append_r <= append_nxt;
      bef_r    <= bef_nxt;
    end
    if (cmd.insert) begin
      for (int k = 0; k < TOP_MAX; k++) begin
        rv_r[k] <= rv_nxt[k];
        rc_r[k] <= rc_nxt[k];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      size_r  <= '0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.lookup && restart_r) begin
        valid_r <= '0;
        size_r  <= '0;
      end
      if (cmd.update && (cur != CNT_MAX)) begin
        valid_r[v_r] <= 1'b1;
      end
      if (cmd.insert) begin
        size_r <= size_nxt;
        n_r    <= n_nxt;
        k_r    <= '0;
      end
      if (cmd.advance) begin
        k_r <= k_r + IDX_W'(1);
      end
    end
  end

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SIZE_W'(TOP_MAX))
    else $error("ranked list grew past its capacity");

  a_rank_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (SIZE_W'(k_r) < n_r) && (n_r <= size_r))
    else $error("result index outside the ranked list");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.locate |-> $onehot0(match_r))
    else $error("value held twice in the ranked list");

endmodule

// File: tb/stream_top_k_frequent_top_test.sv
// ----------------------------------------------------------------------------
// stream_top_k_frequent_top_test
// Self-checking testbench of the streaming top-k frequency ranker. A queue-fed
// driver offers items with random gaps, a monitor takes results under random
// back-pressure, and an in-bench ranking model predicts every result burst.
// ----------------------------------------------------------------------------
module stream_top_k_frequent_top_test
  import skf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 6;
  // longer than one item occupies the block without back-pressure
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 10;

  localparam logic [2:0] TOPK_ADDR   = 3'd0;
  localparam logic [2:0] UNUSED_ADDR = 3'd4;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  restart;
  } stream_item_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  is_last;
  } ranked_result_t;

  // clock, reset and DUT ports; every input starts at a known value
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_item_value = '0;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] out_top_value;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // ranking model state
  logic [COUNT_BITS-1:0] occ_count [CNT_DEPTH];
  logic [VALUE_BITS-1:0] rank_val [TOP_MAX];
  logic [COUNT_BITS-1:0] rank_cnt [TOP_MAX];
  int                    rank_len;
  logic [TOPK_W-1:0]     topk_model;

  stream_item_t   pending_items[$];
  ranked_result_t due_ranks[$];

  int unsigned items_offered = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  stream_top_k_frequent_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item_value(in_item_value),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_top_value(out_top_value),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // Rank order: higher count first, smaller value first on equal counts.
  function automatic bit outranks(input logic [COUNT_BITS-1:0] cnt_a, cnt_b,
                                  input logic [VALUE_BITS-1:0] val_a, val_b);
    if (cnt_a != cnt_b) begin
      return cnt_a > cnt_b;
    end
    return val_a < val_b;
  endfunction

  // Count one item, move it to its rank and queue the result burst it causes.
  function automatic void count_and_rank(input stream_item_t it);
    logic [COUNT_BITS-1:0] cnt;
    logic [VALUE_BITS-1:0] swap_val;
    logic [COUNT_BITS-1:0] swap_cnt;
    int                    slot;
    int                    burst;
    bit                    found;
    bit                    place;
    ranked_result_t        res;
    if (it.restart) begin
      foreach (occ_count[i]) occ_count[i] = '0;
      rank_len = 0;
    end
    cnt = occ_count[it.value];
    // a saturated count stays put and leaves the ranking alone
    if (cnt != CNT_MAX) begin
      cnt = cnt + COUNT_BITS'(1);
      occ_count[it.value] = cnt;
      slot = rank_len;
      found = 1'b0;
      place = 1'b0;
      for (int k = 0; k < rank_len; k++) begin
        if (!found && rank_val[k] == it.value) begin
          slot = k;
          found = 1'b1;
        end
      end
      if (found) begin
        place = 1'b1;
      end else if (rank_len < TOP_MAX) begin
        slot = rank_len;
        rank_len++;
        place = 1'b1;
      end else if (outranks(cnt, rank_cnt[TOP_MAX-1], it.value, rank_val[TOP_MAX-1])) begin
        // full list: evict the tail only when the newcomer beats it
        slot = TOP_MAX - 1;
        place = 1'b1;
      end
      if (place) begin
        rank_val[slot] = it.value;
        rank_cnt[slot] = cnt;
        while (slot > 0 && outranks(rank_cnt[slot], rank_cnt[slot-1],
                                    rank_val[slot], rank_val[slot-1])) begin
          swap_val = rank_val[slot-1];
          swap_cnt = rank_cnt[slot-1];
          rank_val[slot-1] = rank_val[slot];
          rank_cnt[slot-1] = rank_cnt[slot];
          rank_val[slot] = swap_val;
          rank_cnt[slot] = swap_cnt;
          slot--;
        end
      end
    end
    // clip top_k to the list capacity and to the values seen so far
    burst = (topk_model > TOP_MAX) ? TOP_MAX : int'(topk_model);
    if (burst > rank_len) begin
      burst = rank_len;
    end
    for (int k = 0; k < burst; k++) begin
      res.value = rank_val[k];
      res.is_last = (k == burst - 1);
      due_ranks = {due_ranks, res};
    end
  endfunction

  // Driver: hold the offered item until it is taken, then offer the next one
  // or idle. Valid never looks at in_stall.
  always @(negedge clk) begin
    stream_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || items_taken == items_offered) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_item_value <= it.value;
        in_restart <= it.restart;
        in_valid <= 1'b1;
        items_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Acceptance: predict the burst of every item the block takes.
  always @(posedge clk) begin
    stream_item_t it;
    if (rst_n && in_valid && !in_stall) begin
      it.value = in_item_value;
      it.restart = in_restart;
      count_and_rank(it);
      items_taken++;
    end
  end

  // Receiver: random stall, or a long hold-off counted here when one is asked.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: compare each taken result with the oldest one due.
  always @(posedge clk) begin
    ranked_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result: value %0d last %0b", out_top_value, out_last);
        end
      end else begin
        want = due_ranks.pop_front();
        if (out_top_value !== want.value || out_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result mismatch: expected value %0d last %0b, got value %0d last %0b",
                     want.value, want.is_last, out_top_value, out_last);
          end
        end
      end
    end
  end

  // APB write: setup cycle, access cycle, then drop the select.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == TOPK_ADDR) begin
      topk_model = data[TOPK_W-1:0];
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Write top_k with random bits above the field.
  task automatic set_top_k(input int unsigned k);
    apb_write(TOPK_ADDR, ($urandom() & ~32'h1f) | (k & 32'h1f));
  endtask

  function automatic void push_item(input logic [VALUE_BITS-1:0] value, input logic restart);
    stream_item_t it;
    it.value = value;
    it.restart = restart;
    pending_items = {pending_items, it};
  endfunction

  // Mostly a small pool of values so the list fills and entries compete,
  // now and then any value, and a rare restart.
  function automatic void push_random(input int unsigned count);
    logic [VALUE_BITS-1:0] value;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 75) begin
        value = VALUE_BITS'($urandom_range(23));
      end else begin
        value = VALUE_BITS'($urandom_range(CNT_DEPTH - 1));
      end
      push_item(value, $urandom_range(99) < 4);
    end
  endfunction

  // Wait until every item is taken and every result has come, then let the
  // block finish any item that causes no result.
  task automatic wait_drained();
    do @(posedge clk); while (pending_items.size() != 0 || in_valid || due_ranks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random phase: push half, pause the sender until drained, push the rest.
  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                              input int unsigned k, input bit long_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_top_k(k);
    push_random(45);
    if (long_hold) begin
      holds_asked++;
    end
    wait_drained();
    push_random(45);
    wait_drained();
  endtask

  initial begin
    foreach (occ_count[i]) occ_count[i] = '0;
    rank_len = 0;
    topk_model = TOPK_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // reset top_k of one; equal counts put the smaller value first
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    wait_drained();

    // a write to an unmapped register must not disturb top_k
    apb_write(UNUSED_ADDR, $urandom());
    // top_k above the list size clips to the list size
    set_top_k(31);
    for (int v = 16; v < 32; v++) begin
      push_item(VALUE_BITS'(v), v == 16);
    end
    // full list: a larger value on a tie stays out, a smaller one evicts the tail
    push_item(8'd40, 1'b0);
    push_item(8'd5, 1'b0);
    push_item(8'd5, 1'b0);
    wait_drained();

    // top_k of zero: items are counted but nothing comes out
    set_top_k(0);
    push_item(8'd7, 1'b0);
    push_item(8'hAA, 1'b1);
    wait_drained();

    random_phase(8, 63, $urandom_range(2, 15), 1'b0);
    random_phase(63, 8, TOP_MAX, 1'b0);
    // no idling here, but a long hold-off backs up the block
    random_phase(0, 0, $urandom_range(17, 31), 1'b1);

    if (mismatches == 0 && due_ranks.size() == 0) begin
      $display("stream_top_k_frequent_top regression: pass");
    end else begin
      $display("stream_top_k_frequent_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("stream_top_k_frequent_top regression: fail");
    $finish;
  end

endmodule
